/* hdl/ccts_pkg.sv */
`timescale 1ns / 1ps

package ccts_pkg;

  // Datapath widths
  localparam int unsigned TOTAL_W  = 64;
  localparam int unsigned DIVR_W   = 32;
  localparam int unsigned HALF_W   = 32;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned SECS_W   = 55;
  localparam int unsigned PART_W   = 10;
  localparam int unsigned CPS_W    = 32;
  localparam int unsigned CPM_W    = 23;
  localparam int unsigned CPU_W    = 13;
  localparam int unsigned CNT_W    = $clog2(TOTAL_W + 1);

  // Configuration port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_CPS = 2'd0,
    REG_CPM = 2'd1,
    REG_CPU = 2'd2
  } reg_idx_e;

  localparam logic [CPS_W-1:0] CPS_RESET = 32'd168000000;
  localparam logic [CPM_W-1:0] CPM_RESET = 23'd168000;
  localparam logic [CPU_W-1:0] CPU_RESET = 13'd168;

  // Unit scaling constants, consumed one bit per cycle
  localparam int unsigned SEC_MUL_W   = 20;
  localparam int unsigned MILLI_MUL_W = 10;
  localparam int unsigned STEP_W      = $clog2(SEC_MUL_W);
  localparam logic [SEC_MUL_W-1:0]   MICROS_PER_SECOND = 20'd1000000;
  localparam logic [MILLI_MUL_W-1:0] MICROS_PER_MILLI  = 10'd1000;
  localparam logic [PART_W-1:0]      PART_MAX          = 10'd999;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_S,
    ST_DIV_MS,
    ST_DIV_US,
    ST_SCALE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [PART_W-1:0] sat_part(input logic [TOTAL_W-1:0] q);
    logic [PART_W-1:0] r;
    if (q > TOTAL_W'(PART_MAX)) begin
      r = PART_MAX;
    end else begin
      r = q[PART_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/ccts_if.sv */
`timescale 1ns / 1ps

interface ccts_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] cycle_sample;

  modport source (output valid, output cycle_sample, input ready);
  modport sink (input valid, input cycle_sample, output ready);
endinterface

interface ccts_out_if;
  logic        valid;
  logic        ready;
  logic [54:0] whole_seconds;
  logic [9:0]  millis_part;
  logic [9:0]  micros_part;
  logic [63:0] total_micros;

  modport source (output valid, output whole_seconds, output millis_part,
                  output micros_part, output total_micros, input ready);
  modport sink (input valid, input whole_seconds, input millis_part,
                input micros_part, input total_micros, output ready);
endinterface

/* hdl/ccts_div.sv */
`timescale 1ns / 1ps

module ccts_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ccts_pkg::TOTAL_W-1:0]  dividend_i,
  input  logic [ccts_pkg::DIVR_W-1:0]   divisor_i,
  output ccts_pkg::div_stat_t           stat_o,
  output logic [ccts_pkg::TOTAL_W-1:0]  quotient_o,
  output logic [ccts_pkg::TOTAL_W-1:0]  remainder_o
);

  localparam int unsigned TW = ccts_pkg::TOTAL_W;
  localparam int unsigned DW = ccts_pkg::DIVR_W;
  localparam int unsigned CW = ccts_pkg::CNT_W;
  localparam int unsigned HW = ccts_pkg::HALF_W;

  logic          busy_q, done_q, zero_q;
  logic [CW-1:0] cnt_q;
  logic [TW-1:0] num_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dvs_q;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        fits;
  logic        start_zero;
  logic        start_short;

  // Restoring division, one quotient bit per cycle
  assign trial       = {rem_q, num_q[TW-1]};
  assign diff        = trial - {1'b0, dvs_q};
  assign fits        = (trial >= {1'b0, dvs_q});
  assign start_zero  = (divisor_i == '0);
  assign start_short = (dividend_i[TW-1:HW] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        zero_q <= start_zero;
        busy_q <= !start_zero;
        done_q <= start_zero;
        cnt_q  <= start_short ? CW'(HW) : CW'(TW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      // Skip the empty upper half when the dividend fits in the lower half
      if (!start_zero && start_short) begin
        num_q <= {dividend_i[HW-1:0], {(TW-HW){1'b0}}};
      end else begin
        num_q <= dividend_i;
      end
    end else if (busy_q) begin
      rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
      num_q <= {num_q[TW-2:0], fits};
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = zero_q ? {TW{1'b1}} : num_q;
  assign remainder_o  = zero_q ? num_q : {{(TW-DW){1'b0}}, rem_q};

endmodule

/* hdl/ccts_scale.sv */
`timescale 1ns / 1ps

module ccts_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ccts_pkg::TOTAL_W-1:0]  seconds_i,
  input  logic [ccts_pkg::PART_W-1:0]   millis_i,
  input  logic [ccts_pkg::PART_W-1:0]   micros_i,
  output logic                          done_o,
  output logic [ccts_pkg::TOTAL_W-1:0]  total_o
);

  localparam int unsigned TW = ccts_pkg::TOTAL_W;
  localparam int unsigned SW = ccts_pkg::STEP_W;
  localparam int unsigned MW = ccts_pkg::SEC_MUL_W;
  localparam int unsigned LW = ccts_pkg::MILLI_MUL_W;
  localparam int unsigned LIW = $clog2(LW);

  logic          busy_q, done_q;
  logic [SW-1:0] k_q;
  logic [TW-1:0] acc_q;
  logic [TW-1:0] sec_sh_q;
  logic [MW-1:0] ms_sh_q;

  logic [TW-1:0] add_s;
  logic [TW-1:0] add_m;
  logic          last;

  // Shift-and-add against the constant bits, low bit first
  assign add_s = ccts_pkg::MICROS_PER_SECOND[k_q] ? sec_sh_q : '0;
  assign add_m = ((k_q < SW'(LW)) && ccts_pkg::MICROS_PER_MILLI[k_q[LIW-1:0]]) ?
                 {{(TW-MW){1'b0}}, ms_sh_q} : '0;
  assign last  = (k_q == SW'(MW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end else if (busy_q) begin
        k_q <= k_q + SW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= {{(TW-ccts_pkg::PART_W){1'b0}}, micros_i};
      sec_sh_q <= seconds_i;
      ms_sh_q  <= {{(MW-ccts_pkg::PART_W){1'b0}}, millis_i};
    end else if (busy_q) begin
      acc_q    <= acc_q + add_s + add_m;
      sec_sh_q <= {sec_sh_q[TW-2:0], 1'b0};
      ms_sh_q  <= {ms_sh_q[MW-2:0], 1'b0};
    end
  end

  assign done_o  = done_q;
  assign total_o = acc_q;

endmodule

/* hdl/cycle_count_timebase_split_core.sv */
`timescale 1ns / 1ps

// Extends samples of a free-running cycle counter into a 64-bit cycle total
// (a wrap is counted whenever a sample falls below the previous one) and
// splits it into whole seconds, milliseconds, microseconds and a microsecond
// total. One request is worked at a time. All three divisions share one
// restoring divider that retires one quotient bit per cycle; it skips the
// empty upper half of a dividend that fits in 32 bits and finishes any
// zero divisor without iterating. A serial shift-and-add scaler then forms
// the microsecond total, and the result is loaded into the output register,
// which holds that result while the next request is accepted.
module cycle_count_timebase_split_core #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ccts_in_if.sink                       in_if,
  ccts_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ccts_pkg::ADDR_W-1:0]   paddr,
  input  logic [ccts_pkg::DATA_W-1:0]   pwdata,
  output logic [ccts_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned TW = ccts_pkg::TOTAL_W;
  localparam int unsigned SMW = ccts_pkg::SAMPLE_W;
  localparam int unsigned PW = ccts_pkg::PART_W;
  localparam logic [SMW-1:0] SAMPLE_MASK =
    (COUNTER_BITS >= SMW) ? {SMW{1'b1}} : SMW'((64'd1 << COUNTER_BITS) - 64'd1);

  ccts_pkg::state_e state_q, state_d;

  logic [ccts_pkg::CPS_W-1:0] cps_q;
  logic [ccts_pkg::CPM_W-1:0] cpm_q;
  logic [ccts_pkg::CPU_W-1:0] cpu_q;

  logic [SMW-1:0] prev_q;
  logic [SMW-1:0] wrap_q;
  logic [TW-1:0]  secs_q;
  logic [PW-1:0]  ms_q;
  logic [PW-1:0]  us_q;

  logic                         out_valid_q;
  logic [ccts_pkg::SECS_W-1:0]  out_secs_q;
  logic [PW-1:0]                out_ms_q;
  logic [PW-1:0]                out_us_q;
  logic [TW-1:0]                out_total_q;

  logic [SMW-1:0] sample;
  logic [SMW-1:0] wrap_next;
  logic [TW-1:0]  total_c;
  logic           accept;
  logic           in_ready;
  logic           out_free;
  logic           out_load;

  logic                      div_start;
  logic [TW-1:0]             div_dividend;
  logic [ccts_pkg::DIVR_W-1:0] div_divisor;
  ccts_pkg::div_stat_t       div_stat;
  logic [TW-1:0]             div_quo;
  logic [TW-1:0]             div_rem;
  logic [PW-1:0]             quo_sat;

  logic           scale_start;
  logic           scale_done;
  logic [TW-1:0]  scale_total;

  logic                          cfg_wr;
  logic [ccts_pkg::IDX_W-1:0]    cfg_idx;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ccts_pkg::ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q <= ccts_pkg::CPS_RESET;
      cpm_q <= ccts_pkg::CPM_RESET;
      cpu_q <= ccts_pkg::CPU_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ccts_pkg::REG_CPS: cps_q <= pwdata[ccts_pkg::CPS_W-1:0];
        ccts_pkg::REG_CPM: cpm_q <= pwdata[ccts_pkg::CPM_W-1:0];
        ccts_pkg::REG_CPU: cpu_q <= pwdata[ccts_pkg::CPU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ccts_pkg::REG_CPS: prdata = cps_q;
      ccts_pkg::REG_CPM: prdata = ccts_pkg::DATA_W'(cpm_q);
      ccts_pkg::REG_CPU: prdata = ccts_pkg::DATA_W'(cpu_q);
      default:           prdata = '0;
    endcase
  end

  // Wrap extension
  assign sample    = in_if.cycle_sample & SAMPLE_MASK;
  assign wrap_next = (sample < prev_q) ? wrap_q + SMW'(1) : wrap_q;
  assign total_c   = (TW'(wrap_next) << COUNTER_BITS) | TW'(sample);
  assign accept    = in_if.valid && in_ready;
  assign quo_sat   = ccts_pkg::sat_part(div_quo);
  assign out_free  = !out_valid_q || out_if.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ccts_pkg::ST_IDLE:   if (in_if.valid) state_d = ccts_pkg::ST_DIV_S;
      ccts_pkg::ST_DIV_S:  if (div_stat.done) state_d = ccts_pkg::ST_DIV_MS;
      ccts_pkg::ST_DIV_MS: if (div_stat.done) state_d = ccts_pkg::ST_DIV_US;
      ccts_pkg::ST_DIV_US: if (div_stat.done) state_d = ccts_pkg::ST_SCALE;
      ccts_pkg::ST_SCALE:  if (scale_done) state_d = ccts_pkg::ST_OUT;
      ccts_pkg::ST_OUT:    if (out_free) state_d = ccts_pkg::ST_IDLE;
      default:             state_d = ccts_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_rem;
    div_divisor  = cps_q;
    scale_start  = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      ccts_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        div_start    = in_if.valid;
        div_dividend = total_c;
      end
      ccts_pkg::ST_DIV_S: begin
        div_start   = div_stat.done;
        div_divisor = ccts_pkg::DIVR_W'(cpm_q);
      end
      ccts_pkg::ST_DIV_MS: begin
        div_start   = div_stat.done;
        div_divisor = ccts_pkg::DIVR_W'(cpu_q);
      end
      ccts_pkg::ST_DIV_US: scale_start = div_stat.done;
      ccts_pkg::ST_SCALE:  ;
      ccts_pkg::ST_OUT:    out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccts_pkg::ST_IDLE;
      prev_q      <= '0;
      wrap_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        prev_q <= sample;
        wrap_q <= wrap_next;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ccts_pkg::ST_DIV_S && div_stat.done) begin
      secs_q <= div_quo;
    end
    if (state_q == ccts_pkg::ST_DIV_MS && div_stat.done) begin
      ms_q <= quo_sat;
    end
    if (state_q == ccts_pkg::ST_DIV_US && div_stat.done) begin
      us_q <= quo_sat;
    end
    if (out_load) begin
      out_secs_q  <= secs_q[ccts_pkg::SECS_W-1:0];
      out_ms_q    <= ms_q;
      out_us_q    <= us_q;
      out_total_q <= scale_total;
    end
  end

  ccts_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  ccts_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scale_start),
    .seconds_i (secs_q),
    .millis_i  (ms_q),
    .micros_i  (quo_sat),
    .done_o    (scale_done),
    .total_o   (scale_total)
  );

  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_valid_q;
  assign out_if.whole_seconds = out_secs_q;
  assign out_if.millis_part   = out_ms_q;
  assign out_if.micros_part   = out_us_q;
  assign out_if.total_micros  = out_total_q;

  // A zero divisor finishes at once, so the divider is either busy or done
  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ccts_pkg::ST_DIV_S) && (div_stat.busy || div_stat.done))
    else $error("accepted request did not start the seconds division");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ccts_pkg::ST_DIV_S ||
                       state_q == ccts_pkg::ST_DIV_MS ||
                       state_q == ccts_pkg::ST_DIV_US))
    else $error("divider finished outside a division step");

  a_scale_done_in_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_done |-> (state_q == ccts_pkg::ST_SCALE))
    else $error("scaler finished outside the scaling step");

  a_parts_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_ms_q <= ccts_pkg::PART_MAX) && (out_us_q <= ccts_pkg::PART_MAX))
    else $error("sub-second part above saturation limit");

endmodule

/* bench/ccts_timebase_checker.sv */
`timescale 1ns / 1ps

module ccts_timebase_checker #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [31:0]                   in_sample_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [ccts_pkg::SECS_W-1:0]   out_secs_i,
  input  logic [ccts_pkg::PART_W-1:0]   out_millis_i,
  input  logic [ccts_pkg::PART_W-1:0]   out_micros_i,
  input  logic [63:0]                   out_total_us_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [ccts_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [ccts_pkg::DATA_W-1:0]   pwdata_i,
  input  logic [ccts_pkg::DATA_W-1:0]   prdata_i,
  input  logic                          pready_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);

  typedef struct packed {
    logic [ccts_pkg::SECS_W-1:0] secs;
    logic [ccts_pkg::PART_W-1:0] millis;
    logic [ccts_pkg::PART_W-1:0] micros;
    logic [63:0]                 total_us;
  } stamp_t;

  localparam logic [63:0] US_PER_S   = 64'd1000000;
  localparam logic [63:0] US_PER_MS  = 64'd1000;
  localparam logic [63:0] PART_LIMIT = 64'd999;
  localparam logic [31:0] SAMPLE_MASK =
    (COUNTER_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << COUNTER_BITS) - 32'd1);

  logic [31:0]                  last_sample = '0;
  logic [31:0]                  wraps = '0;
  logic [ccts_pkg::CPS_W-1:0]   cyc_per_s = ccts_pkg::CPS_RESET;
  logic [ccts_pkg::CPM_W-1:0]   cyc_per_ms = ccts_pkg::CPM_RESET;
  logic [ccts_pkg::CPU_W-1:0]   cyc_per_us = ccts_pkg::CPU_RESET;
  stamp_t                       stamps_due[$];

  function automatic logic [ccts_pkg::PART_W-1:0] clamp_part(input logic [63:0] q);
    return (q > PART_LIMIT) ? ccts_pkg::PART_W'(PART_LIMIT) : q[ccts_pkg::PART_W-1:0];
  endfunction

  // A zero divisor yields an all-ones quotient and leaves the dividend as remainder.
  function automatic stamp_t split_total(input logic [63:0] total,
                                         input logic [ccts_pkg::CPS_W-1:0] s_div,
                                         input logic [ccts_pkg::CPM_W-1:0] m_div,
                                         input logic [ccts_pkg::CPU_W-1:0] u_div);
    logic [63:0] secs;
    logic [63:0] rem_s;
    logic [63:0] q_ms;
    logic [63:0] rem_ms;
    logic [63:0] q_us;
    stamp_t      st;
    if (s_div == '0) begin
      secs  = '1;
      rem_s = total;
    end else begin
      secs  = total / 64'(s_div);
      rem_s = total % 64'(s_div);
    end
    if (m_div == '0) begin
      q_ms   = '1;
      rem_ms = rem_s;
    end else begin
      q_ms   = rem_s / 64'(m_div);
      rem_ms = rem_s % 64'(m_div);
    end
    q_us = (u_div == '0) ? '1 : rem_ms / 64'(u_div);
    st.secs     = secs[ccts_pkg::SECS_W-1:0];
    st.millis   = clamp_part(q_ms);
    st.micros   = clamp_part(q_us);
    st.total_us = secs * US_PER_S + 64'(st.millis) * US_PER_MS + 64'(st.micros);
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stamp_t                      want;
    logic [31:0]                 s;
    logic [ccts_pkg::DATA_W-1:0] reg_val;
    logic                        known;
    if (!rst_ni) begin
      last_sample = '0;
      wraps       = '0;
      cyc_per_s   = ccts_pkg::CPS_RESET;
      cyc_per_ms  = ccts_pkg::CPM_RESET;
      cyc_per_us  = ccts_pkg::CPU_RESET;
      stamps_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (stamps_due.size() == 0) begin
          $error("timestamp with no request pending: secs %0d ms %0d us %0d",
                 out_secs_i, out_millis_i, out_micros_i);
          fail_count_o++;
        end else begin
          want = stamps_due.pop_front();
          checked_o++;
          if (out_secs_i !== want.secs) begin
            $error("whole_seconds: expected %0d, got %0d", want.secs, out_secs_i);
            fail_count_o++;
          end
          if (out_millis_i !== want.millis) begin
            $error("millis_part: expected %0d, got %0d", want.millis, out_millis_i);
            fail_count_o++;
          end
          if (out_micros_i !== want.micros) begin
            $error("micros_part: expected %0d, got %0d", want.micros, out_micros_i);
            fail_count_o++;
          end
          if (out_total_us_i !== want.total_us) begin
            $error("total_micros: expected %0d, got %0d", want.total_us, out_total_us_i);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        s = in_sample_i & SAMPLE_MASK;
        if (s < last_sample) wraps = wraps + 32'd1;
        last_sample = s;
        stamps_due.push_back(split_total((64'(wraps) << COUNTER_BITS) + 64'(s),
                                         cyc_per_s, cyc_per_ms, cyc_per_us));
      end

      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i[ccts_pkg::ADDR_W-1:2])
            ccts_pkg::REG_CPS: cyc_per_s  = pwdata_i[ccts_pkg::CPS_W-1:0];
            ccts_pkg::REG_CPM: cyc_per_ms = pwdata_i[ccts_pkg::CPM_W-1:0];
            ccts_pkg::REG_CPU: cyc_per_us = pwdata_i[ccts_pkg::CPU_W-1:0];
            default: ;
          endcase
        end else begin
          known = 1'b1;
          case (paddr_i[ccts_pkg::ADDR_W-1:2])
            ccts_pkg::REG_CPS: reg_val = ccts_pkg::DATA_W'(cyc_per_s);
            ccts_pkg::REG_CPM: reg_val = ccts_pkg::DATA_W'(cyc_per_ms);
            ccts_pkg::REG_CPU: reg_val = ccts_pkg::DATA_W'(cyc_per_us);
            default: begin
              reg_val = '0;
              known   = 1'b0;
            end
          endcase
          if (known && prdata_i !== reg_val) begin
            $error("prdata at 0x%0h: expected %0d, got %0d", paddr_i, reg_val, prdata_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = stamps_due.size();
  end

endmodule

/* bench/cycle_count_timebase_split_core_test.sv */
`timescale 1ns / 1ps

module cycle_count_timebase_split_core_test;

  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 150;
  localparam int QUIET_PHASE    = 5;
  localparam int HOLD_PHASE     = 3;
  localparam logic [ccts_pkg::IDX_W-1:0] REG_SPARE = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ccts_pkg::ADDR_W-1:0] paddr = '0;
  logic [ccts_pkg::DATA_W-1:0] pwdata = '0;
  logic [ccts_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  bit          gaps_on = 1'b1;
  bit          hold_off_req = 1'b0;
  int          idle_cycles = 0;
  int          samples_sent = 0;
  int          settings = 0;
  int          fails;
  int          pending;
  int          checked;
  logic [31:0] counter_now = '0;

  ccts_in_if  in_ch ();
  ccts_out_if out_ch ();

  cycle_count_timebase_split_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ccts_timebase_checker timebase_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_ch.valid),
    .in_ready_i     (in_ch.ready),
    .in_sample_i    (in_ch.cycle_sample),
    .out_valid_i    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .out_secs_i     (out_ch.whole_seconds),
    .out_millis_i   (out_ch.millis_part),
    .out_micros_i   (out_ch.micros_part),
    .out_total_us_i (out_ch.total_micros),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .fail_count_o   (fails),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly a counter that advances, with natural wraps; some repeats, jumps and steps back.
  function automatic logic [31:0] next_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      counter_now = counter_now + $urandom_range(1, 5000);
    end else if (pick < 70) begin
      counter_now = counter_now + ($urandom & 32'h1FFF_FFFF);
    end else if (pick < 80) begin
      counter_now = $urandom;
    end else if (pick < 88) begin
      counter_now = counter_now - $urandom_range(1, 1000);
    end else if (pick < 95) begin
      counter_now = ($urandom_range(0, 1) != 0) ? 32'h0 : 32'hFFFF_FFFF;
    end
    return counter_now;
  endfunction

  task automatic send_sample(input logic [31:0] s);
    while (gaps_on && $urandom_range(0, 99) < 38) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cycle_sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [ccts_pkg::IDX_W-1:0] idx,
                            input logic [ccts_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ccts_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_back();
    reg_access(1'b0, ccts_pkg::REG_CPS, '0);
    reg_access(1'b0, ccts_pkg::REG_CPM, '0);
    reg_access(1'b0, ccts_pkg::REG_CPU, '0);
  endtask

  task automatic program_timebase(input logic [31:0] s, input logic [31:0] m,
                                  input logic [31:0] u);
    reg_access(1'b1, ccts_pkg::REG_CPS, s);
    reg_access(1'b1, ccts_pkg::REG_CPM, m);
    reg_access(1'b1, ccts_pkg::REG_CPU, u);
    read_back();
    settings++;
  endtask

  // Drop valid, drain every outstanding request, then let the divider go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 38);
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("no request moved for %0d cycles, %0d still pending", idle_cycles, pending);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.cycle_sample = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    read_back();

    // Reset divisors: edges of each unit, counter top, wrap and an equal sample.
    send_sample(32'd0);
    send_sample(32'd1);
    send_sample(32'd167);
    send_sample(32'd168);
    send_sample(32'd167999);
    send_sample(32'd168000);
    send_sample(32'd167999999);
    send_sample(32'd168000000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'd0);
    send_sample(32'd0);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);

    // All divisors zero: all-ones seconds, saturated parts.
    settle();
    program_timebase(32'd0, 32'd0, 32'd0);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'd12345);

    // Inconsistent: millisecond quotients far above 999, microsecond quotients zero.
    settle();
    program_timebase(32'hFFFF_FFFF, 32'd1, 32'd1);
    send_sample($urandom);
    send_sample($urandom);

    // Top of range for the sub-second divisors; write to an unused index is dropped.
    settle();
    program_timebase(32'd1000, 32'd4294967, 32'd4294);
    reg_access(1'b1, REG_SPARE, $urandom);
    read_back();
    send_sample($urandom);
    send_sample($urandom);

    // Seconds divisor below range, sub-second divisors at full field width.
    settle();
    program_timebase(32'd1, 32'h007F_FFFF, 32'h0000_1FFF);
    send_sample($urandom);
    send_sample($urandom);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      logic [31:0] s_div;
      logic [31:0] m_div;
      logic [31:0] u_div;
      settle();
      if (p == 0) begin
        s_div = 32'(ccts_pkg::CPS_RESET);
        m_div = 32'(ccts_pkg::CPM_RESET);
        u_div = 32'(ccts_pkg::CPU_RESET);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            u_div = $urandom_range(1, 4294);
            m_div = u_div * 32'd1000;
            s_div = m_div * 32'd1000;
          end
          1: begin
            s_div = ($urandom_range(0, 1) != 0) ? 32'd1000 : 32'hFFFF_FFFF;
            m_div = ($urandom_range(0, 1) != 0) ? 32'd1 : 32'd4294967;
            u_div = ($urandom_range(0, 1) != 0) ? 32'd1 : 32'd4294;
          end
          2: begin
            s_div = $urandom;
            m_div = $urandom;
            u_div = $urandom;
          end
          default: begin
            s_div = ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom_range(1, 999);
            m_div = ($urandom_range(0, 3) == 0) ? 32'd0 : ($urandom & 32'h007F_FFFF);
            u_div = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 8191);
          end
        endcase
      end
      program_timebase(s_div, m_div, u_div);
      gaps_on = (p != QUIET_PHASE);
      if (p == HOLD_PHASE) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) send_sample(next_sample());
    end
    settle();

    $display("checked %0d timestamps from %0d counter samples", checked, samples_sent);
    $display("across %0d divisor settings, incl. zero, saturating and full-width", settings);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", fails);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ccts_pkg.sv
hdl/ccts_if.sv
hdl/ccts_div.sv
hdl/ccts_scale.sv
hdl/cycle_count_timebase_split_core.sv
bench/ccts_timebase_checker.sv
bench/cycle_count_timebase_split_core_test.sv
